### rtl/core/tpp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the track point predictor.
// No dependencies; imported by tpp_divider, track_point_predictor and the test bench.

package tpp_pkg;

   localparam int REG_W     = 13;  // frame size registers
   localparam int FRAME_W   = 32;  // frame numbers
   localparam int OP_W      = 2;
   localparam int CSR_IDX_W = 1;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR   = 2'd0,
      OP_APPEND  = 2'd1,
      OP_PREDICT = 2'd2,
      OP_NONE    = 2'd3
   } tpp_op_type;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [REG_W-1:0] FRAME_WIDTH_RST  = 13'd1280;
   localparam logic [REG_W-1:0] FRAME_HEIGHT_RST = 13'd720;

   // Divider status back to the sequencer.
   typedef struct packed {
      logic done;  // one-cycle pulse, quotient valid
      logic ovf;   // quotient does not fit the quotient width
   } tpp_div_status_type;

endpackage

### rtl/core/track_point_predictor.sv
`timescale 1ns / 1ps
// Constant-velocity point predictor for one feature track: three-point
// history, sequencer and shared multiplier/divider. Depends on tpp_pkg, tpp_divider.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------------
//  req     | in        | req_tvalid / req_tready  | tuser op; tdata x, y, frame number
//  rsp     | out       | rsp_tvalid / rsp_tready  | tdata pred x, y; tuser fell_back, ok
//  csr     | in        | csr_valid / csr_ready    | csr_index, csr_data (frame w / h)
//
// Clear, append and unused ops finish in the accepting cycle; a predict that needs
// no division passes through PREP and EMIT. With three points and a nonzero frame
// half-difference the one multiplier and the divider run once for x, then once for
// y, each time through MUL, LOAD and WAIT; the divider gives one bit per cycle.
// req_tready is high only while the sequencer is idle. A finished result waits in
// the rsp register; the sequencer holds in its last state until it is free.
// Synchronous active-high reset empties the history and loads 1280 x 720.

module track_point_predictor #(
   parameter int  COORD_BITS = 12,
   localparam int REQ_W      = ((2 * COORD_BITS + tpp_pkg::FRAME_W + 7) / 8) * 8,
   localparam int RSP_W      = ((2 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                           clock,
   input  logic                           reset,
   // tdata: point_x, point_y, frame_seq (low bit up), zero padded
   input  logic [REQ_W-1:0]               req_tdata,
   // tuser: operation
   input  logic [tpp_pkg::OP_W-1:0]       req_tuser,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // tdata: pred_x, pred_y (low bit up), zero padded
   output logic [RSP_W-1:0]               rsp_tdata,
   // tuser: fell_back, predict_ok (low bit up)
   output logic [1:0]                     rsp_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tpp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tpp_pkg::REG_W-1:0]      csr_data
);
   import tpp_pkg::*;

   localparam int C      = COORD_BITS;
   localparam int QB     = C + 1;            // quotient bits worth computing
   localparam int PROD_W = C + FRAME_W;
   localparam int VW     = C + 3;            // signed candidate coordinate
   localparam int CMP_W  = (VW - 1 > REG_W) ? VW - 1 : REG_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_LOAD,
      ST_WAIT,
      ST_EMIT
   } state_type;

   state_type             state_ff;
   logic [C-1:0]          hist_x_ff [3];
   logic [C-1:0]          hist_y_ff [3];
   logic [FRAME_W-1:0]    hist_f_ff [3];
   logic [1:0]            count_ff;
   logic [REG_W-1:0]      frame_width_ff;
   logic [REG_W-1:0]      frame_height_ff;
   logic [FRAME_W-1:0]    fseq_ff;
   logic [FRAME_W-1:0]    gap_mag_ff;
   logic                  gap_neg_ff;
   logic [FRAME_W-1:0]    half_mag_ff;
   logic                  half_neg_ff;
   logic [PROD_W-1:0]     prod_mag_ff;
   logic                  q_neg_ff;
   logic                  comp_ff;
   logic signed [VW-1:0]  cand_x_ff;
   logic signed [VW-1:0]  cand_y_ff;
   logic                  fall_ff;
   logic                  ok_ff;
   logic [RSP_W-1:0]      rsp_data_ff;
   logic [1:0]            rsp_user_ff;
   logic                  rsp_valid_ff;

   tpp_op_type            req_op;
   logic                  req_fire;
   logic [C-1:0]          req_x;
   logic [C-1:0]          req_y;
   logic [FRAME_W-1:0]    req_frame;

   logic signed [FRAME_W:0] fdiff, half, half_abs;
   logic signed [FRAME_W:0] gap, gap_abs;
   logic                    half_zero;
   logic [C-1:0]            d0, d2;
   logic signed [C:0]       ddiff, dhalf, dabs;
   logic [PROD_W-1:0]       prod;
   logic signed [VW-1:0]    qval;
   logic signed [VW-1:0]    cand_div;
   logic signed [VW-1:0]    cand2_x, cand2_y;
   logic                    x_ok, y_ok, use_newest;
   logic                    slot_free;
   logic                    div_start;
   logic [QB-1:0]           div_quot;
   tpp_div_status_type      div_status;

   assign req_op     = tpp_op_type'(req_tuser);
   assign req_x      = req_tdata[C-1:0];
   assign req_y      = req_tdata[2*C-1:C];
   assign req_frame  = req_tdata[2*C+FRAME_W-1:2*C];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign div_start  = (state_ff == ST_LOAD);

   always_comb begin
      // frame half-difference and gap, both from the newest frame
      fdiff     = {1'b0, hist_f_ff[0]} - {1'b0, hist_f_ff[2]};
      half      = fdiff >>> 1;
      half_abs  = half[FRAME_W] ? -half : half;
      half_zero = (half == '0);
      gap       = {1'b0, fseq_ff} - {1'b0, hist_f_ff[0]};
      gap_abs   = gap[FRAME_W] ? -gap : gap;

      // position half-difference for the coordinate in work
      d0    = comp_ff ? hist_y_ff[0] : hist_x_ff[0];
      d2    = comp_ff ? hist_y_ff[2] : hist_x_ff[2];
      ddiff = {1'b0, d0} - {1'b0, d2};
      dhalf = ddiff >>> 1;
      dabs  = dhalf[C] ? -dhalf : dhalf;
      prod  = dabs[C-1:0] * gap_mag_ff;

      qval     = q_neg_ff ? -VW'(div_quot) : VW'(div_quot);
      cand_div = VW'(d0) + qval;

      cand2_x = VW'({hist_x_ff[0], 1'b0}) - VW'(hist_x_ff[1]);
      cand2_y = VW'({hist_y_ff[0], 1'b0}) - VW'(hist_y_ff[1]);

      x_ok = !cand_x_ff[VW-1] && (cand_x_ff[VW-2:C] == '0)
             && (CMP_W'(cand_x_ff[VW-2:0]) < CMP_W'(frame_width_ff));
      y_ok = !cand_y_ff[VW-1] && (cand_y_ff[VW-2:C] == '0)
             && (CMP_W'(cand_y_ff[VW-2:0]) < CMP_W'(frame_height_ff));
      use_newest = fall_ff || !x_ok || !y_ok;
   end

   tpp_divider #(
      .QUOT_W (QB),
      .NUM_W  (PROD_W),
      .DEN_W  (FRAME_W)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (prod_mag_ff),
      .den    (half_mag_ff),
      .quot   (div_quot),
      .status (div_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         count_ff        <= 2'd0;
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
         rsp_valid_ff    <= 1'b0;
         comp_ff         <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data;
               CSR_FRAME_HEIGHT: frame_height_ff <= csr_data;
               default: ;
            endcase
         end

         // drop the result once taken, unless a new one is loaded
         if (rsp_tready && state_ff != ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  case (req_op)
                     OP_CLEAR: count_ff <= 2'd0;
                     OP_APPEND: begin
                        hist_x_ff[2] <= hist_x_ff[1];
                        hist_y_ff[2] <= hist_y_ff[1];
                        hist_f_ff[2] <= hist_f_ff[1];
                        hist_x_ff[1] <= hist_x_ff[0];
                        hist_y_ff[1] <= hist_y_ff[0];
                        hist_f_ff[1] <= hist_f_ff[0];
                        hist_x_ff[0] <= req_x;
                        hist_y_ff[0] <= req_y;
                        hist_f_ff[0] <= req_frame;
                        if (count_ff != 2'd3) begin
                           count_ff <= count_ff + 2'd1;
                        end
                     end
                     OP_PREDICT: begin
                        fseq_ff  <= req_frame;
                        state_ff <= ST_PREP;
                     end
                     default: ;
                  endcase
               end
            end

            ST_PREP: begin
               ok_ff       <= (count_ff != 2'd0);
               fall_ff     <= (count_ff == 2'd3) && half_zero;
               comp_ff     <= 1'b0;
               gap_mag_ff  <= gap_abs[FRAME_W-1:0];
               gap_neg_ff  <= gap[FRAME_W];
               half_mag_ff <= half_abs[FRAME_W-1:0];
               half_neg_ff <= half[FRAME_W];
               if (count_ff == 2'd2) begin
                  cand_x_ff <= cand2_x;
                  cand_y_ff <= cand2_y;
               end else begin
                  cand_x_ff <= VW'(hist_x_ff[0]);
                  cand_y_ff <= VW'(hist_y_ff[0]);
               end
               if ((count_ff == 2'd3) && !half_zero) begin
                  state_ff <= ST_MUL;
               end else begin
                  state_ff <= ST_EMIT;
               end
            end

            ST_MUL: begin
               prod_mag_ff <= prod;
               q_neg_ff    <= dhalf[C] ^ gap_neg_ff ^ half_neg_ff;
               state_ff    <= ST_LOAD;
            end

            ST_LOAD: state_ff <= ST_WAIT;

            ST_WAIT: begin
               if (div_status.done) begin
                  if (div_status.ovf) begin
                     fall_ff <= 1'b1;
                  end
                  if (comp_ff) begin
                     cand_y_ff <= cand_div;
                     state_ff  <= ST_EMIT;
                  end else begin
                     cand_x_ff <= cand_div;
                     comp_ff   <= 1'b1;
                     state_ff  <= ST_MUL;
                  end
               end
            end

            ST_EMIT: begin
               // hold until the result register is free
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  if (!ok_ff) begin
                     rsp_data_ff <= '0;
                     rsp_user_ff <= 2'b00;
                  end else if (use_newest) begin
                     rsp_data_ff <= RSP_W'({hist_y_ff[0], hist_x_ff[0]});
                     rsp_user_ff <= 2'b11;
                  end else begin
                     rsp_data_ff <= RSP_W'({cand_y_ff[C-1:0], cand_x_ff[C-1:0]});
                     rsp_user_ff <= 2'b10;
                  end
                  state_ff <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

### rtl/core/tpp_divider.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle, with an early
// overflow exit. Depends on tpp_pkg (status struct).

module tpp_divider #(
   parameter int QUOT_W = 13,
   parameter int NUM_W  = 44,
   parameter int DEN_W  = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [NUM_W-1:0]                  num,
   input  logic [DEN_W-1:0]                  den,
   output logic [QUOT_W-1:0]                 quot,
   output tpp_pkg::tpp_div_status_type       status
);
   import tpp_pkg::*;

   // Upper numerator bits must fit the divisor width.
   localparam int HI_W  = NUM_W - QUOT_W;
   localparam int CNT_W = $clog2(QUOT_W + 1);

   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff;
   logic [QUOT_W-1:0] low_ff;
   logic [QUOT_W-1:0] quot_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic              ovf_ff;

   logic [HI_W-1:0]   num_hi;
   logic              ovf_now;
   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    trial_diff;
   logic              qbit;

   always_comb begin
      num_hi     = num[NUM_W-1:QUOT_W];
      // quotient >= 2^QUOT_W exactly when the upper bits already reach the divisor
      ovf_now    = DEN_W'(num_hi) >= den;
      trial      = {rem_ff, low_ff[QUOT_W-1]};
      trial_diff = trial - {1'b0, den_ff};
      qbit       = trial >= {1'b0, den_ff};
      rem_in     = qbit ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= !ovf_now;
            done_ff <= ovf_now;
            cnt_ff  <= CNT_W'(QUOT_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= DEN_W'(num_hi);
         low_ff  <= num[QUOT_W-1:0];
         den_ff  <= den;
         quot_ff <= '0;
         ovf_ff  <= ovf_now;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         low_ff  <= {low_ff[QUOT_W-2:0], 1'b0};
         quot_ff <= {quot_ff[QUOT_W-2:0], qbit};
      end
   end

   assign quot        = quot_ff;
   assign status.done = done_ff;
   assign status.ovf  = ovf_ff;

endmodule

### tb/track_point_predictor_test.sv
`timescale 1ns / 1ps
// Self-checking bench for track_point_predictor: drives clear/append/predict requests and
// frame-size register writes, checks every result against a cycle-free track forecaster.
// Depends on tpp_pkg and the track_point_predictor RTL.

module track_point_predictor_test;
   import tpp_pkg::*;

   localparam int COORD_BITS    = 12;
   localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
   localparam int REQ_W         = ((2 * COORD_BITS + FRAME_W + 7) / 8) * 8;
   localparam int RSP_W         = ((2 * COORD_BITS + 7) / 8) * 8;
   localparam int SETTLE_CYCLES = 60;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  fell_back;
      logic                  ok;
   } track_point_type;

   // Forecasts each predict request from its own copy of the track history.
   class track_forecast_type;
      logic [COORD_BITS-1:0] hist_x[3];
      logic [COORD_BITS-1:0] hist_y[3];
      logic [FRAME_W-1:0]    hist_frame[3];
      int unsigned           points;
      logic [REG_W-1:0]      frame_w;
      logic [REG_W-1:0]      frame_h;
      track_point_type       pending_points[$];
      int unsigned           errors;

      function new();
         frame_w = FRAME_WIDTH_RST;
         frame_h = FRAME_HEIGHT_RST;
         errors  = 0;
         forget_history();
      endfunction

      function void forget_history();
         for (int i = 0; i < 3; i++) begin
            hist_x[i]     = '0;
            hist_y[i]     = '0;
            hist_frame[i] = '0;
         end
         points = 0;
      endfunction

      function void note_register(logic [CSR_IDX_W-1:0] idx, logic [REG_W-1:0] val);
         if (idx == CSR_FRAME_WIDTH) frame_w = val;
         else frame_h = val;
      endfunction

      function bit in_frame(longint v, logic [REG_W-1:0] lim);
         longint lim_l;
         lim_l = lim;
         return v >= 0 && v < lim_l && v <= COORD_MAX;
      endfunction

      function void note_request(tpp_op_type op, logic [COORD_BITS-1:0] x,
                                 logic [COORD_BITS-1:0] y, logic [FRAME_W-1:0] f);
         track_point_type want;
         longint x0, y0, px, py, dx, dy, f0, f2, half, gap;
         bit fall;
         case (op)
            OP_CLEAR: forget_history();
            OP_APPEND: begin
               for (int i = 2; i > 0; i--) begin
                  hist_x[i]     = hist_x[i-1];
                  hist_y[i]     = hist_y[i-1];
                  hist_frame[i] = hist_frame[i-1];
               end
               hist_x[0]     = x;
               hist_y[0]     = y;
               hist_frame[0] = f;
               if (points < 3) points++;
            end
            OP_PREDICT: begin
               want = '0;
               if (points != 0) begin
                  x0   = hist_x[0];
                  y0   = hist_y[0];
                  px   = x0;
                  py   = y0;
                  fall = 1'b0;
                  if (points == 2) begin
                     dx = hist_x[1];
                     dy = hist_y[1];
                     px = x0 + (x0 - dx);
                     py = y0 + (y0 - dy);
                  end else if (points == 3) begin
                     dx   = hist_x[2];
                     dy   = hist_y[2];
                     dx   = (x0 - dx) >>> 1;
                     dy   = (y0 - dy) >>> 1;
                     f0   = hist_frame[0];
                     f2   = hist_frame[2];
                     half = (f0 - f2) >>> 1;
                     gap  = f;
                     gap  = gap - f0;
                     if (half == 0) begin
                        fall = 1'b1;
                     end else begin
                        px = x0 + (dx * gap) / half;
                        py = y0 + (dy * gap) / half;
                     end
                  end
                  if (fall || !in_frame(px, frame_w) || !in_frame(py, frame_h)) begin
                     fall = 1'b1;
                     px   = x0;
                     py   = y0;
                  end
                  want.x         = px[COORD_BITS-1:0];
                  want.y         = py[COORD_BITS-1:0];
                  want.fell_back = fall;
                  want.ok        = 1'b1;
               end
               pending_points.push_back(want);
            end
            default: ;
         endcase
      endfunction

      task report_mismatch(string msg);
         // keep the log short on a badly broken block
         if (errors < 40) $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_result(track_point_type got);
         track_point_type want;
         if (pending_points.size() == 0) begin
            report_mismatch($sformatf("unexpected result x=%0d y=%0d fell_back=%0b ok=%0b",
                                      got.x, got.y, got.fell_back, got.ok));
            return;
         end
         want = pending_points.pop_front();
         if (got.x !== want.x)
            report_mismatch($sformatf("pred_x got %0d want %0d", got.x, want.x));
         if (got.y !== want.y)
            report_mismatch($sformatf("pred_y got %0d want %0d", got.y, want.y));
         if (got.fell_back !== want.fell_back)
            report_mismatch($sformatf("fell_back got %0b want %0b", got.fell_back,
                                      want.fell_back));
         if (got.ok !== want.ok)
            report_mismatch($sformatf("predict_ok got %0b want %0b", got.ok, want.ok));
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic [OP_W-1:0]      req_tuser = OP_NONE;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [RSP_W-1:0]     rsp_tdata;
   logic [1:0]           rsp_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [REG_W-1:0]     csr_data = '0;

   track_forecast_type sb;
   int unsigned   sent = 0;
   int unsigned   send_idle_pct = 0;
   int unsigned   rsp_stall_pct = 0;
   bit            hold_rsp = 1'b0;
   int            cfg_w = 1280;
   int            cfg_h = 720;
   int unsigned   cycle_count = 0;

   track_point_predictor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("track_point_predictor regression: fail");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result({rsp_tdata[COORD_BITS-1:0], rsp_tdata[2*COORD_BITS-1:COORD_BITS],
                          rsp_tuser[0], rsp_tuser[1]});
   end

   task automatic send_request(input tpp_op_type op, input logic [COORD_BITS-1:0] x,
                               input logic [COORD_BITS-1:0] y, input logic [FRAME_W-1:0] f);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {f, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, x, y, f);
      if (op != OP_NONE) sent++;
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.note_register(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drop valid, then wait for every forecast point to come back.
   task automatic await_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending_points.size() != 0) @(posedge clock);
   endtask

   task automatic settle_block();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [COORD_BITS-1:0] clip_coord(int v);
      if (v < 0) return '0;
      if (v > COORD_MAX) return '1;
      return v[COORD_BITS-1:0];
   endfunction

   // One plausible track: optional clear, a few appends along a line, then predicts.
   task automatic run_track();
      int                 npts, cx, cy, vx, vy, span_x, span_y;
      logic [FRAME_W-1:0] f, last;
      int unsigned        step;
      span_x = (cfg_w == 0 || cfg_w > COORD_MAX + 1) ? COORD_MAX : cfg_w - 1;
      span_y = (cfg_h == 0 || cfg_h > COORD_MAX + 1) ? COORD_MAX : cfg_h - 1;
      if ($urandom_range(3) == 0)
         send_request(OP_CLEAR, COORD_BITS'($urandom), COORD_BITS'($urandom), $urandom);
      npts = ($urandom_range(9) < 2) ? $urandom_range(1, 2) : $urandom_range(3, 5);
      cx   = $urandom_range(span_x);
      cy   = $urandom_range(span_y);
      vx   = $urandom_range(40);
      vx  -= 20;
      vy   = $urandom_range(40);
      vy  -= 20;
      if ($urandom_range(9) == 0) begin
         vx *= 50;
         vy *= 50;
      end
      step = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
      f    = ($urandom_range(7) == 0) ? 32'hFFFF_FFF0 + $urandom_range(8) : $urandom;
      last = f;
      repeat (npts) begin
         send_request(OP_APPEND, clip_coord(cx), clip_coord(cy), f);
         last = f;
         cx  += vx;
         cy  += vy;
         f   += step;
      end
      repeat ($urandom_range(1, 4))
         send_request(OP_PREDICT, COORD_BITS'($urandom), COORD_BITS'($urandom),
                      last + FRAME_W'($urandom_range(12)) - 32'd4);
   endtask

   task automatic run_phase(input logic [REG_W-1:0] w, input logic [REG_W-1:0] h,
                            input int unsigned send_pct, input int unsigned stall_pct,
                            input int unsigned items, input bit hold_first,
                            input bit pause_midway);
      int unsigned goal;
      bit          paused;
      await_results();
      settle_block();
      write_register(CSR_FRAME_WIDTH, w);
      write_register(CSR_FRAME_HEIGHT, h);
      cfg_w         = w;
      cfg_h         = h;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      hold_rsp      = hold_first;
      goal          = sent + items;
      paused        = 1'b0;
      while (sent < goal) begin
         if ($urandom_range(99) < 80)
            run_track();
         else
            send_request(tpp_op_type'($urandom_range(3)), COORD_BITS'($urandom),
                         COORD_BITS'($urandom), $urandom);
         if (pause_midway && !paused && sent >= goal - items / 2) begin
            await_results();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty history, ignored op with every field bit set
      send_request(OP_PREDICT, '1, '1, '1);
      send_request(OP_NONE, '1, '1, '1);
      // single point, then two points running far outside the frame
      send_request(OP_APPEND, '0, '0, '0);
      send_request(OP_PREDICT, '0, '0, 32'd5);
      send_request(OP_APPEND, '1, '1, '1);
      send_request(OP_PREDICT, '0, '0, '0);
      // two points in frame, then three with steady motion
      send_request(OP_CLEAR, '1, '1, '1);
      send_request(OP_APPEND, 12'd100, 12'd200, 32'd10);
      send_request(OP_APPEND, 12'd110, 12'd190, 32'd11);
      send_request(OP_PREDICT, '0, '0, 32'd12);
      send_request(OP_APPEND, 12'd120, 12'd180, 32'd12);
      send_request(OP_PREDICT, '0, '0, 32'd15);
      send_request(OP_PREDICT, '0, '0, 32'd0);
      send_request(OP_PREDICT, '0, '0, 32'd30);
      send_request(OP_PREDICT, '0, '0, 32'd31);
      // half frame difference rounds to zero
      send_request(OP_APPEND, 12'd121, 12'd181, 32'd12);
      send_request(OP_PREDICT, '0, '0, 32'd13);
      // frame numbers wrapping past the top
      send_request(OP_CLEAR, '0, '0, '0);
      send_request(OP_APPEND, 12'd50, 12'd50, 32'hFFFF_FFFE);
      send_request(OP_APPEND, 12'd52, 12'd52, 32'hFFFF_FFFF);
      send_request(OP_APPEND, 12'd54, 12'd54, 32'd0);
      send_request(OP_PREDICT, '0, '0, 32'd1);
      // decreasing frames: odd negative halving, truncation toward zero
      send_request(OP_APPEND, 12'd200, 12'd200, 32'd20);
      send_request(OP_APPEND, 12'd190, 12'd190, 32'd17);
      send_request(OP_APPEND, 12'd180, 12'd180, 32'd15);
      send_request(OP_PREDICT, '0, '0, 32'd21);
      send_request(OP_PREDICT, '0, '0, 32'd16);
      send_request(OP_PREDICT, '0, '0, 32'd1000);

      run_phase(13'd4096, 13'd4096, 0, 0, 150, 1'b0, 1'b0);
      run_phase(13'd640, 13'd480, 83, 0, 150, 1'b0, 1'b0);
      run_phase(13'd1, 13'd1, 0, 83, 100, 1'b0, 1'b0);
      run_phase(13'd8191, 13'd0, 13, 13, 100, 1'b0, 1'b0);
      run_phase(13'd0, 13'd8191, 0, 0, 100, 1'b1, 1'b0);
      run_phase(REG_W'($urandom_range(1, 4096)), REG_W'($urandom_range(1, 4096)), 13, 13,
                150, 1'b0, 1'b1);

      await_results();
      settle_block();
      if (sb.errors == 0 && sb.pending_points.size() == 0)
         $display("track_point_predictor regression: pass");
      else
         $display("track_point_predictor regression: fail");
      $finish;
   end

endmodule
